// ===== rtl/sat_pkg.sv =====
// Shared types and constants for the shell argument tokenizer.
package sat_pkg;

	// Argument limit and field widths
	localparam int MaxArgs   = 16;
	localparam int CntW      = 5;
	localparam int IdxW      = 4;
	localparam int ChW       = 8;
	localparam int QueueDepth = 4;
	localparam int QPtrW     = 2;
	localparam int QCntW     = 3;

	// Scan modes
	localparam logic [2:0] MODE_BETWEEN = 3'd0;
	localparam logic [2:0] MODE_WORD    = 3'd1;
	localparam logic [2:0] MODE_WESC    = 3'd2;
	localparam logic [2:0] MODE_DQ      = 3'd3;
	localparam logic [2:0] MODE_DESC    = 3'd4;
	localparam logic [2:0] MODE_SQ      = 3'd5;
	localparam logic [2:0] MODE_IGNORE  = 3'd6;

	// Result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOA  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// Special characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// One result beat
	typedef struct packed {
		logic [1:0]      kind;
		logic [ChW-1:0]  ch;
		logic [IdxW-1:0] idx;
		logic [CntW-1:0] cnt;
		logic            last;
	} res_t;

endpackage

// ===== rtl/sat_scan.sv =====
// Combinational scanner: next mode, argument count and up to two results per byte.
module sat_scan
	import sat_pkg::*;
(
	input  logic [7:0]      ch,
	input  logic [2:0]      mode,
	input  logic [CntW-1:0] args,
	input  logic [CntW-1:0] limit,
	output logic [2:0]      mode_nxt,
	output logic [CntW-1:0] args_nxt,
	output logic [1:0]      n_res,
	output res_t            res0,
	output res_t            res1
);

	logic            blank;
	logic [2:0]      m;
	logic [CntW-1:0] a;
	logic [IdxW-1:0] cur;
	logic            go;

	assign blank = (ch == CH_SPACE) || (ch == CH_TAB);

	always_comb begin
		m        = mode;
		a        = args;
		go       = 1'b1;
		mode_nxt = mode;
		args_nxt = args;
		n_res    = 2'd0;
		res0     = '0;
		res1     = '0;
		cur      = IdxW'(args - CntW'(1));
		if (ch == CH_NUL) begin
			// End of line: close an open word, then report the count
			go       = 1'b0;
			mode_nxt = MODE_BETWEEN;
			args_nxt = '0;
			if (mode >= MODE_WORD && mode <= MODE_SQ) begin
				res0  = '{kind: KIND_EOA, ch: '0, idx: cur, cnt: args, last: 1'b0};
				res1  = '{kind: KIND_EOL, ch: '0, idx: '0, cnt: args, last: 1'b1};
				n_res = 2'd2;
			end else begin
				res0  = '{kind: KIND_EOL, ch: '0, idx: '0, cnt: args, last: 1'b1};
				n_res = 2'd1;
			end
		end else if (mode == MODE_BETWEEN) begin
			// Word start: skip blanks, drop comments and words past the limit
			if (blank) begin
				go = 1'b0;
			end else if (ch == CH_HASH || args >= limit) begin
				go       = 1'b0;
				mode_nxt = MODE_IGNORE;
			end else begin
				a        = args + CntW'(1);
				cur      = IdxW'(args);
				m        = MODE_WORD;
				args_nxt = a;
			end
		end
		if (go) begin
			mode_nxt = m;
			unique case (m)
				MODE_WORD: begin
					if (blank) begin
						res0     = '{kind: KIND_EOA, ch: '0, idx: cur, cnt: a, last: 1'b1};
						n_res    = 2'd1;
						mode_nxt = MODE_BETWEEN;
					end else if (ch == CH_BSLASH) begin
						mode_nxt = MODE_WESC;
					end else if (ch == CH_DQUOTE) begin
						mode_nxt = MODE_DQ;
					end else if (ch == CH_SQUOTE) begin
						mode_nxt = MODE_SQ;
					end else begin
						res0  = '{kind: KIND_BYTE, ch: ch, idx: cur, cnt: a, last: 1'b1};
						n_res = 2'd1;
					end
				end
				MODE_WESC: begin
					res0     = '{kind: KIND_BYTE, ch: ch, idx: cur, cnt: a, last: 1'b1};
					n_res    = 2'd1;
					mode_nxt = MODE_WORD;
				end
				MODE_DQ: begin
					if (ch == CH_DQUOTE) begin
						mode_nxt = MODE_WORD;
					end else if (ch == CH_BSLASH) begin
						mode_nxt = MODE_DESC;
					end else begin
						res0  = '{kind: KIND_BYTE, ch: ch, idx: cur, cnt: a, last: 1'b1};
						n_res = 2'd1;
					end
				end
				MODE_DESC: begin
					res0     = '{kind: KIND_BYTE, ch: ch, idx: cur, cnt: a, last: 1'b1};
					n_res    = 2'd1;
					mode_nxt = MODE_DQ;
				end
				MODE_SQ: begin
					if (ch == CH_SQUOTE) begin
						mode_nxt = MODE_WORD;
					end else begin
						res0  = '{kind: KIND_BYTE, ch: ch, idx: cur, cnt: a, last: 1'b1};
						n_res = 2'd1;
					end
				end
				default: begin
					mode_nxt = MODE_IGNORE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sat_outq.sv =====
// Small result queue: takes up to two results per cycle, hands out one per beat.
module sat_outq
	import sat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  res_t             din0,
	input  res_t             din1,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             dout,
	output logic [QCntW-1:0] count
);

	res_t             mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;
	logic             pop;
	logic [QPtrW-1:0] wr1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign dout      = mem_q[rd_q];
	assign count     = cnt_q;
	assign wr1       = wr_q + QPtrW'(1);

	// Store new results at the tail
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= din0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr1] <= din1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPtrW'(push_n);
			rd_q  <= rd_q + QPtrW'(pop);
			cnt_q <= cnt_q + QCntW'(push_n) - QCntW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QueueDepth))
		else $error("result queue over capacity");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (cnt_q + QCntW'(push_n) - QCntW'(pop) <= QCntW'(QueueDepth)))
		else $error("result queue push overflows");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rd_q == $past(rd_q) + QPtrW'(1))
		else $error("read pointer did not advance on pop");
`endif

endmodule

// ===== rtl/shell_argument_tokenizer.sv =====
// Top level: shell command-line word splitter with a streaming in/out interface.
//
//  channel  dir  beat contents
//  s_*      in   tdata[7:0] ch (0 ends the line)
//  m_*      out  tdata: out_ch[7:0] arg_index[11:8] arg_count[16:12]; tuser kind; tlast last
//  cfg_*    in   cfg_wdata max_args, written when cfg_we is high
//
// One input byte is decoded in the cycle it is accepted; its zero to two results
// land in a four-entry result queue and leave one per cycle from there while m_tready is high.
// Input is accepted whenever the queue holds two or fewer results, so a steady
// byte-per-cycle stream runs at full rate while the output is ready; a byte that yields two results
// (end of line inside a word) costs one extra output beat.
// Reset: between words, no arguments, max_args 16, queue empty.
module shell_argument_tokenizer
	import sat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_ch, [11:8] arg_index, [16:12] arg_count
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	logic [CntW-1:0]  max_q;
	logic [2:0]       mode_q;
	logic [CntW-1:0]  args_q;
	logic [CntW-1:0]  limit;
	logic [2:0]       mode_nxt;
	logic [CntW-1:0]  args_nxt;
	logic [1:0]       n_res;
	res_t             res0;
	res_t             res1;
	res_t             head;
	logic [QCntW-1:0] q_count;
	logic             acc;
	logic [1:0]       push_n;

	// Clamp the limit to at most MaxArgs
	assign limit = (max_q > CntW'(MaxArgs)) ? CntW'(MaxArgs) : max_q;

	// Take a beat only while the queue can absorb two results
	assign s_tready = (q_count <= QCntW'(QueueDepth - 2));
	assign acc      = s_tvalid && s_tready;
	assign push_n   = acc ? n_res : 2'd0;

	sat_scan u_scan (
		.ch       (s_tdata),
		.mode     (mode_q),
		.args     (args_q),
		.limit    (limit),
		.mode_nxt (mode_nxt),
		.args_nxt (args_nxt),
		.n_res    (n_res),
		.res0     (res0),
		.res1     (res1)
	);

	sat_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.din0      (res0),
		.din1      (res1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dout      (head),
		.count     (q_count)
	);

	// Drive the result beat
	assign m_tdata = {7'd0, head.cnt, head.idx, head.ch};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// Update config and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= CntW'(MaxArgs);
			mode_q <= MODE_BETWEEN;
			args_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (acc) begin
				mode_q <= mode_nxt;
				args_q <= args_nxt;
			end
		end
	end

`ifndef SYNTHESIS
	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tdata == CH_NUL) |=> (args_q == '0 && mode_q == MODE_BETWEEN))
		else $error("end of line did not clear scan state");
	a_args_bound: assert property (@(posedge clk) disable iff (!arst_n)
		args_q <= CntW'(MaxArgs))
		else $error("argument count above limit");
	a_eol_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tdata == CH_NUL) |-> (push_n != 2'd0))
		else $error("end of line produced no result");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the shell argument tokenizer.
module tb;
	import sat_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] ch
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [7:0] out_ch, [11:8] arg_index, [16:12] arg_count
	logic [1:0]  m_tuser;          // [1:0] kind
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	// Line bytes waiting to be sent and token beats waiting to arrive
	logic [7:0] byte_queue [$];
	res_t       expected_tokens [$];

	// Scanner state as tracked by the checker
	logic [2:0]      scan_st     = MODE_BETWEEN;
	logic [CntW-1:0] word_cnt    = '0;
	logic [4:0]      max_setting = 5'd16;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fail_count    = 0;
	int bytes_pushed  = 0;
	int bytes_sent    = 0;
	int beats_checked = 0;
	int lines_seen    = 0;
	int cfg_writes    = 0;

	shell_argument_tokenizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic res_t token(input logic [1:0] kind, input logic [7:0] c,
			input logic [IdxW-1:0] idx);
		res_t r;
		r.kind = kind;
		r.ch   = c;
		r.idx  = idx;
		r.cnt  = word_cnt;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the scanner by one byte and queue the token beats it yields
	task automatic split_byte(input logic [7:0] c);
		res_t            outs [2];
		int              n;
		int              lim;
		logic [IdxW-1:0] cur;
		n   = 0;
		cur = IdxW'(word_cnt - 1'b1);
		lim = (int'(max_setting) < MaxArgs) ? int'(max_setting) : MaxArgs;
		if (c == CH_NUL) begin
			if (scan_st >= MODE_WORD && scan_st <= MODE_SQ) begin
				outs[n] = token(KIND_EOA, 8'h00, cur);
				n++;
			end
			outs[n] = token(KIND_EOL, 8'h00, '0);
			n++;
			scan_st  = MODE_BETWEEN;
			word_cnt = '0;
		end else begin
			// Word start: drop blanks, enter comment or limit skip, else open a word
			if (scan_st == MODE_BETWEEN) begin
				if (is_blank(c))
					return;
				if (c == CH_HASH || int'(word_cnt) >= lim) begin
					scan_st = MODE_IGNORE;
					return;
				end
				word_cnt = word_cnt + 1'b1;
				cur      = IdxW'(word_cnt - 1'b1);
				scan_st  = MODE_WORD;
			end
			case (scan_st)
				MODE_WORD: begin
					if (is_blank(c)) begin
						outs[n] = token(KIND_EOA, 8'h00, cur);
						n++;
						scan_st = MODE_BETWEEN;
					end else if (c == CH_BSLASH) begin
						scan_st = MODE_WESC;
					end else if (c == CH_DQUOTE) begin
						scan_st = MODE_DQ;
					end else if (c == CH_SQUOTE) begin
						scan_st = MODE_SQ;
					end else begin
						outs[n] = token(KIND_BYTE, c, cur);
						n++;
					end
				end
				MODE_WESC: begin
					outs[n] = token(KIND_BYTE, c, cur);
					n++;
					scan_st = MODE_WORD;
				end
				MODE_DQ: begin
					if (c == CH_DQUOTE) begin
						scan_st = MODE_WORD;
					end else if (c == CH_BSLASH) begin
						scan_st = MODE_DESC;
					end else begin
						outs[n] = token(KIND_BYTE, c, cur);
						n++;
					end
				end
				MODE_DESC: begin
					outs[n] = token(KIND_BYTE, c, cur);
					n++;
					scan_st = MODE_DQ;
				end
				MODE_SQ: begin
					if (c == CH_SQUOTE) begin
						scan_st = MODE_WORD;
					end else begin
						outs[n] = token(KIND_BYTE, c, cur);
						n++;
					end
				end
				default: begin
					scan_st = MODE_IGNORE;
				end
			endcase
		end
		if (n > 0)
			outs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(outs[i]);
	endtask

	task automatic note_fail(input string what);
		if (fail_count < 10)
			$display("mismatch: %s", what);
		fail_count++;
	endtask

	// Feed line bytes, predict each accepted beat, track register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				split_byte(s_tdata);
				bytes_sent++;
			end
			if (cfg_we)
				max_setting = cfg_wdata;
			if (!s_tvalid || s_tready) begin
				if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= byte_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each token beat against the oldest prediction, stall at random
	always @(posedge clk) begin : monitor
		res_t        want;
		logic [23:0] want_data;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_checked++;
				if (expected_tokens.size() == 0) begin
					note_fail($sformatf("unexpected beat tdata=%h tuser=%0d tlast=%0b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want      = expected_tokens.pop_front();
					want_data = {7'b0, want.cnt, want.idx, want.ch};
					if (want.kind == KIND_EOL)
						lines_seen++;
					if (m_tdata !== want_data || m_tuser !== want.kind
							|| m_tlast !== want.last)
						note_fail($sformatf({"exp tdata=%h tuser=%0d tlast=%0b, ",
							"got tdata=%h tuser=%0d tlast=%0b"}, want_data, want.kind,
							want.last, m_tdata, m_tuser, m_tlast));
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		byte_queue.push_back(b);
		bytes_pushed++;
	endtask

	// Pick a byte with no special meaning inside a word
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(9) < 7)
				b = 8'($urandom_range(8'h7E, 8'h21));
			else
				b = 8'($urandom_range(255, 1));
		end while (is_blank(b) || b == CH_BSLASH || b == CH_DQUOTE || b == CH_SQUOTE);
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		return ($urandom_range(1) != 0) ? CH_SPACE : CH_TAB;
	endfunction

	task automatic push_dq_body();
		int len;
		int pick;
		len = $urandom_range(4);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				push_byte(blank_byte());
			end else if (pick < 35) begin
				push_byte(CH_BSLASH);
				push_byte(8'($urandom_range(255, 1)));
			end else if (pick < 45) begin
				push_byte(CH_SQUOTE);
			end else begin
				push_byte(plain_byte());
			end
		end
	endtask

	task automatic push_sq_body();
		int         len;
		logic [7:0] b;
		len = $urandom_range(4);
		for (int i = 0; i < len; i++) begin
			do b = 8'($urandom_range(255, 1)); while (b == CH_SQUOTE);
			push_byte(b);
		end
	endtask

	// Build one word from plain runs, escapes and quoted pieces
	task automatic push_word();
		int pieces;
		if ($urandom_range(99) < 8) begin
			push_byte(CH_HASH);
			push_sq_body();
			return;
		end
		pieces = $urandom_range(3, 1);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(5))
				0, 1: begin
					for (int i = $urandom_range(4, 1); i > 0; i--)
						push_byte(plain_byte());
				end
				2: begin
					push_byte(CH_BSLASH);
					push_byte(8'($urandom_range(255, 1)));
				end
				3: begin
					push_byte(CH_DQUOTE);
					push_dq_body();
					push_byte(CH_DQUOTE);
				end
				4: begin
					push_byte(CH_SQUOTE);
					push_sq_body();
					push_byte(CH_SQUOTE);
				end
				default: begin
					push_byte(($urandom_range(1) != 0) ? CH_DQUOTE : CH_SQUOTE);
					push_byte(byte_queue[$]);
				end
			endcase
		end
	endtask

	// Emit one command line ending in NUL; a few are raw noise
	task automatic push_line();
		int words;
		int tail;
		if ($urandom_range(99) < 15) begin
			for (int i = $urandom_range(15); i > 0; i--)
				push_byte(8'($urandom_range(255)));
			push_byte(CH_NUL);
			return;
		end
		words = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(6);
		for (int i = $urandom_range(2); i > 0; i--)
			push_byte(blank_byte());
		for (int w = 0; w < words; w++) begin
			if (w > 0) begin
				for (int i = $urandom_range(3, 1); i > 0; i--)
					push_byte(blank_byte());
			end
			push_word();
		end
		tail = $urandom_range(9);
		if (tail < 2) begin
			push_byte(blank_byte());
		end else if (tail == 2) begin
			push_byte(CH_BSLASH);
		end else if (tail == 3) begin
			push_byte(CH_DQUOTE);
			push_dq_body();
		end else if (tail == 4) begin
			push_byte(CH_SQUOTE);
			push_sq_body();
		end
		push_byte(CH_NUL);
	endtask

	// Hold until every queued byte is sent and every token beat has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (byte_queue.size() != 0 || s_tvalid || expected_tokens.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(input logic [4:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_writes++;
	endtask

	task automatic set_idle(input int profile);
		case (profile)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 75; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 75; end
			default: begin send_idle_pct = 17; stall_pct = 17; end
		endcase
	endtask

	initial begin : stimulus
		logic [7:0] opening [23];
		logic [4:0] max_steps [8];
		int         start;
		opening = '{
			// blank lead, extreme bytes, tab, quoted blank and escape, dropped
			// trailing backslash
			CH_SPACE, 8'h01, CH_TAB, CH_DQUOTE, CH_SPACE, CH_BSLASH, CH_DQUOTE,
			CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_SQUOTE, 8'hFF, CH_BSLASH, CH_NUL,
			// empty quoted word, then a comment
			CH_DQUOTE, CH_DQUOTE, CH_SPACE, CH_HASH, 8'h7A, CH_NUL,
			// unclosed single quote
			CH_SQUOTE, 8'h71, CH_NUL
		};
		max_steps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd8, 5'd17, 5'd5};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_idle(3);
		foreach (opening[i])
			push_byte(opening[i]);
		// Lower the limit in the middle of a line: the next word is skipped
		push_byte(8'h61);
		push_byte(CH_SPACE);
		wait_drained();
		write_max(5'd1);
		push_byte(8'h62);
		push_byte(CH_NUL);
		wait_drained();

		for (int phase = 0; phase < 8; phase++) begin
			write_max(max_steps[phase]);
			set_idle(phase % 4);
			start = bytes_pushed;
			while (bytes_pushed - start < 45)
				push_line();
			wait_drained();
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d line bytes, checked %0d token beats over %0d lines,",
			bytes_sent, beats_checked, lines_seen);
		$display("with %0d max_args writes and four idle profiles.", cfg_writes);
		if (expected_tokens.size() != 0)
			note_fail($sformatf("%0d token beats never arrived", expected_tokens.size()));
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
